// ----- src/usrh_pkg.sv -----
package usrh_pkg;

    // Default descriptor table depth
    localparam int TABLE_DEPTH_DEF = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TABLE_ENTRIES = 1'b0;   // word index, paddr[2]
    localparam int TE_W = 5;

    // Opcodes
    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Response actions
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_ACK = 3'd1;
    localparam logic [2:0] ACT_STALL = 3'd2;
    localparam logic [2:0] ACT_ZERO = 3'd3;
    localparam logic [2:0] ACT_DESC = 3'd4;

    // bmRequestType values
    localparam logic [7:0] RT_DEV_OUT = 8'h00;
    localparam logic [7:0] RT_IF_OUT = 8'h01;
    localparam logic [7:0] RT_DEV_IN = 8'h80;

    // bRequest values
    localparam logic [7:0] RQ_GET_STATUS = 8'd0;
    localparam logic [7:0] RQ_SET_ADDRESS = 8'd5;
    localparam logic [7:0] RQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] RQ_SET_INTERFACE = 8'd11;

    // Device states
    localparam logic [1:0] DEV_UNCONNECTED = 2'd0;
    localparam logic [1:0] DEV_ADDRESSED = 2'd1;
    localparam logic [1:0] DEV_CONFIGURED = 2'd2;

    // Get-status reply length
    localparam logic [15:0] STATUS_LEN = 16'd2;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  setup_type;
        logic [7:0]  request_code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [3:0]  entry_slot;
        logic [31:0] entry_address;
    } t_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] tx_address;
        logic [15:0] tx_length;
        logic        address_strobe;
        logic [6:0]  new_address;
        logic [1:0]  device_state;
        logic [15:0] configuration_number;
        logic [15:0] interface_number;
    } t_result;

    // One descriptor table entry
    typedef struct packed {
        logic [31:0] key;      // {wValue, wIndex}
        logic [15:0] len;
        logic [31:0] addr;
    } t_entry;

endpackage

// ----- src/usb_setup_request_handler_top.sv -----
// USB control endpoint standard request handler.
//
// Input channel: an item (i_item) is taken at a rising edge with start high
// and busy low. An item either loads one descriptor table slot or carries a
// setup packet, which is decoded with the standard chapter 9 codes.
// Result channel: one result per item, shown on o_result for exactly one
// cycle with o_strobe high. The receiver cannot stall; o_strobe falls
// after that cycle.
// Config: APB-style port, one register, table_entries at byte address 0,
// the number of table slots get-descriptor searches, at most TABLE_DEPTH; with
// zero it stalls. pready is tied high; write only while the block is idle.
// Timing: loads and setup requests other than get-descriptor: strobe registered
// from the exec state and shown with busy low, so the next item is taken at the
// edge ending it. Get-descriptor scans the table memory with one key
// comparator, one entry a cycle, compared the cycle after its registered read;
// it ends at the first hit or last searched entry; a new item waits until then.
// Reset (i_rst_n low, synchronous): device state unconnected, configuration
// and interface values zero, table_entries zero. Table contents are not
// cleared; a slot must be loaded before it lies in the searched range.
module usb_setup_request_handler_top #(
    parameter int TABLE_DEPTH = usrh_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           start,
    output logic                           busy,
    input  usrh_pkg::t_item                i_item,
    // result channel
    output logic                           o_strobe,
    output usrh_pkg::t_result              o_result,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [usrh_pkg::PADDR_W-1:0]   paddr,
    input  logic [usrh_pkg::PDATA_W-1:0]   pwdata,
    output logic [usrh_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [usrh_pkg::TE_W-1:0] r_table_entries;
    logic                      cfg_wr;
    logic                      sel_te;

    logic                      mem_wr_en;
    logic [IDX_W-1:0]          mem_wr_addr;
    usrh_pkg::t_entry          mem_wr_data;
    logic                      mem_rd_en;
    logic [IDX_W-1:0]          mem_rd_addr;
    usrh_pkg::t_entry          mem_rd_data;

    // APB register file: single register, no wait states
    assign pready = 1'b1;
    assign sel_te = paddr[2] == usrh_pkg::REG_TABLE_ENTRIES;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= '0;
        end else if (cfg_wr && sel_te) begin
            r_table_entries <= pwdata[usrh_pkg::TE_W-1:0];
        end
    end

    assign prdata = sel_te ? {{(usrh_pkg::PDATA_W - usrh_pkg::TE_W){1'b0}}, r_table_entries}
                           : '0;

    // Sequencer: decode, device state and table search
    usrh_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_item          (i_item),
        .i_table_entries (r_table_entries),
        .o_busy          (busy),
        .o_strobe        (o_strobe),
        .o_result        (o_result),
        .o_mem_wr_en     (mem_wr_en),
        .o_mem_wr_addr   (mem_wr_addr),
        .o_mem_wr_data   (mem_wr_data),
        .o_mem_rd_en     (mem_rd_en),
        .o_mem_rd_addr   (mem_rd_addr),
        .i_mem_rd_data   (mem_rd_data)
    );

    // Descriptor table: key, length and address per slot
    usrh_desc_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_desc_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

// ----- src/usrh_desc_mem.sv -----
module usrh_desc_mem #(
    parameter int TABLE_DEPTH = usrh_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  usrh_pkg::t_entry   i_wr_data,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output usrh_pkg::t_entry   o_rd_data
);

    usrh_pkg::t_entry r_mem [TABLE_DEPTH];
    usrh_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/usrh_seq.sv -----
module usrh_seq #(
    parameter int TABLE_DEPTH = usrh_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  usrh_pkg::t_item              i_item,
    input  logic [usrh_pkg::TE_W-1:0]    i_table_entries,
    output logic                         o_busy,
    output logic                         o_strobe,
    output usrh_pkg::t_result            o_result,
    output logic                         o_mem_wr_en,
    output logic [IDX_W-1:0]             o_mem_wr_addr,
    output usrh_pkg::t_entry             o_mem_wr_data,
    output logic                         o_mem_rd_en,
    output logic [IDX_W-1:0]             o_mem_rd_addr,
    input  usrh_pkg::t_entry             i_mem_rd_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state             r_state, n_state;
    usrh_pkg::t_item    r_item, n_item;
    logic [1:0]         r_dev_state, n_dev_state;
    logic [15:0]        r_config, n_config;
    logic [15:0]        r_iface, n_iface;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic               r_cmp_vld, n_cmp_vld;
    logic               r_cmp_last, n_cmp_last;
    usrh_pkg::t_result  r_res, n_res;
    logic               r_res_vld, n_res_vld;

    logic [8:0]         slot_ext;
    logic               slot_ok;
    logic [8:0]         te_ext;
    logic [8:0]         lim_ext;
    logic [31:0]        key;
    logic               hit;
    logic [15:0]        clip_len;
    logic               rd_en;
    logic [CNT_W-1:0]   cnt_inc;

    assign slot_ext = {5'b0, r_item.entry_slot};
    assign slot_ok  = slot_ext < 9'(TABLE_DEPTH);
    assign te_ext   = {4'b0, i_table_entries};
    assign lim_ext  = (te_ext > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : te_ext;
    assign key      = {r_item.value, r_item.index};

    // Shared comparator: key match and length clip on the entry just read
    assign hit      = i_mem_rd_data.key == key;
    assign clip_len = (r_item.length < i_mem_rd_data.len) ? r_item.length
                                                         : i_mem_rd_data.len;

    assign rd_en    = (r_state == S_SCAN) && (r_cnt != r_limit);
    assign cnt_inc  = r_cnt + CNT_W'(1);

    assign o_mem_rd_en   = rd_en;
    assign o_mem_rd_addr = r_cnt[IDX_W-1:0];
    assign o_mem_wr_en   = (r_state == S_EXEC) && (r_item.opcode == usrh_pkg::OP_LOAD)
                           && slot_ok;
    assign o_mem_wr_addr = slot_ext[IDX_W-1:0];
    assign o_mem_wr_data = '{key: key, len: r_item.length, addr: r_item.entry_address};

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_dev_state = r_dev_state;
        n_config    = r_config;
        n_iface     = r_iface;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_cmp_vld   = 1'b0;
        n_cmp_last  = r_cmp_last;
        n_res       = r_res;
        n_res_vld   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res = '0;
                n_res.action = usrh_pkg::ACT_NONE;
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
                priority if (r_item.opcode == usrh_pkg::OP_LOAD) begin
                    n_res.action = usrh_pkg::ACT_NONE;
                end else if (r_item.setup_type == usrh_pkg::RT_DEV_OUT) begin
                    n_res.action = usrh_pkg::ACT_ACK;
                    if (r_item.request_code == usrh_pkg::RQ_SET_ADDRESS) begin
                        n_res.address_strobe = 1'b1;
                        n_res.new_address    = r_item.value[6:0];
                        n_dev_state          = usrh_pkg::DEV_ADDRESSED;
                    end else if (r_item.request_code == usrh_pkg::RQ_SET_CONFIGURATION) begin
                        n_config    = r_item.value;
                        n_dev_state = usrh_pkg::DEV_CONFIGURED;
                    end
                end else if (r_item.setup_type == usrh_pkg::RT_IF_OUT) begin
                    n_res.action = usrh_pkg::ACT_ACK;
                    if (r_item.request_code == usrh_pkg::RQ_SET_INTERFACE) begin
                        n_iface = r_item.value;
                    end
                end else if (r_item.setup_type == usrh_pkg::RT_DEV_IN) begin
                    if (r_item.request_code == usrh_pkg::RQ_GET_STATUS) begin
                        n_res.action    = usrh_pkg::ACT_ZERO;
                        n_res.tx_length = usrh_pkg::STATUS_LEN;
                    end else if (r_item.request_code == usrh_pkg::RQ_GET_DESCRIPTOR) begin
                        n_cnt   = '0;
                        n_limit = lim_ext[CNT_W-1:0];
                        if (lim_ext == 9'd0) begin
                            n_res.action = usrh_pkg::ACT_STALL;
                        end else begin
                            n_res_vld = 1'b0;
                            n_state   = S_SCAN;
                        end
                    end
                end else begin
                    n_res.action = usrh_pkg::ACT_STALL;
                end
                n_res.device_state         = n_dev_state;
                n_res.configuration_number = n_config;
                n_res.interface_number     = n_iface;
            end

            S_SCAN: begin
                // Read one entry a cycle, compare it the cycle after
                if (rd_en) begin
                    n_cnt      = cnt_inc;
                    n_cmp_vld  = 1'b1;
                    n_cmp_last = cnt_inc == r_limit;
                end
                if (r_cmp_vld && (hit || r_cmp_last)) begin
                    n_res = '0;
                    n_res.device_state         = r_dev_state;
                    n_res.configuration_number = r_config;
                    n_res.interface_number     = r_iface;
                    if (hit) begin
                        n_res.action     = usrh_pkg::ACT_DESC;
                        n_res.tx_address = i_mem_rd_data.addr;
                        n_res.tx_length  = clip_len;
                    end else begin
                        n_res.action = usrh_pkg::ACT_STALL;
                    end
                    n_res_vld = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev_state <= usrh_pkg::DEV_UNCONNECTED;
            r_config    <= '0;
            r_iface     <= '0;
            r_cmp_vld   <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dev_state <= n_dev_state;
            r_config    <= n_config;
            r_iface     <= n_iface;
            r_cmp_vld   <= n_cmp_vld;
            r_res_vld   <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_cnt      <= n_cnt;
        r_limit    <= n_limit;
        r_cmp_last <= n_cmp_last;
        r_res      <= n_res;
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_res_vld;
    assign o_result = r_res;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> $past(r_state != S_IDLE))
        else $error("result strobe without an item in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state == S_EXEC))
        else $error("accepted item did not start");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= r_limit && r_limit != '0))
        else $error("scan counter beyond search limit");

    a_no_stray_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.action != usrh_pkg::ACT_DESC
                   && r_res.action != usrh_pkg::ACT_ZERO)
        |-> (r_res.tx_length == '0 && r_res.tx_address == '0))
        else $error("transmit fields set without a data response");

    a_addr_strobe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.address_strobe)
        |-> (r_res.action == usrh_pkg::ACT_ACK
             && r_res.device_state == usrh_pkg::DEV_ADDRESSED))
        else $error("address strobe without addressed state");

endmodule
